### design/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared constants, types and helper functions for the glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

   localparam int PATTERN_MAX  = 32;
   localparam int STORED_BYTES = 32;
   localparam int PAT_CAP      = (PATTERN_MAX < STORED_BYTES) ? PATTERN_MAX : STORED_BYTES;
   localparam int POS_W        = PAT_CAP + 1;
   localparam int POS_IDX_W    = $clog2(POS_W);
   localparam int PREFIX_LVLS  = $clog2(POS_W);
   localparam int LEN_W        = 6;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_IDX_W    = 3;
   localparam int WORD_BYTES   = 8;
   localparam int NUM_WORDS    = STORED_BYTES / WORD_BYTES;

   localparam logic [7:0] STAR_BYTE     = 8'h2A;
   localparam logic [7:0] QUESTION_BYTE = 8'h3F;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH  = 3'd0,
      CSR_PATTERN_BYTES_0 = 3'd1,
      CSR_PATTERN_BYTES_1 = 3'd2,
      CSR_PATTERN_BYTES_2 = 3'd3,
      CSR_PATTERN_BYTES_3 = 3'd4
   } csr_idx_type;

   typedef logic [POS_W-1:0] pos_vec_type;

   typedef struct packed {
      logic [LEN_W-1:0]               eff_len;
      pos_vec_type                    keep;
      logic [PAT_CAP-1:0]             star;
      logic [PAT_CAP-1:0]             qmark;
      logic [PAT_CAP-1:0][7:0]        fold_byte;
   } cfg_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   // star closure as a log-depth prefix: a set bit runs forward over star positions
   function automatic pos_vec_type close_stars(input pos_vec_type s,
                                               input cfg_type cfg);
      pos_vec_type c;
      pos_vec_type p;
      pos_vec_type c_nxt;
      pos_vec_type p_nxt;
      c = s & cfg.keep;
      p = '0;
      for (int j = 1; j < POS_W; j++) begin
         p[j] = cfg.star[j-1];
      end
      for (int lvl = 0; lvl < PREFIX_LVLS; lvl++) begin
         c_nxt = c;
         p_nxt = p;
         for (int j = 0; j < POS_W; j++) begin
            if (j >= (1 << lvl)) begin
               c_nxt[j] = c[j] | (p[j] & c[j - (1 << lvl)]);
               p_nxt[j] = p[j] & p[j - (1 << lvl)];
            end
         end
         c = c_nxt;
         p = p_nxt;
      end
      return c;
   endfunction

endpackage

### design/wgm_csr.sv
// ----------------------------------------------------------------------------
// wgm_csr
// Pattern registers and their decode into per-position match controls.
// ----------------------------------------------------------------------------
module wgm_csr
   import wgm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [LEN_W-1:0]                      len_ff;
   logic [LEN_W-1:0]                      len_in;
   logic [NUM_WORDS-1:0][CSR_DATA_W-1:0]  words_ff;
   logic [NUM_WORDS-1:0][CSR_DATA_W-1:0]  words_in;
   logic [LEN_W-1:0]                      eff_len;
   logic [STORED_BYTES-1:0][7:0]          all_bytes;

   always_comb begin
      len_in   = len_ff;
      words_in = words_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH:  len_in      = csr_wdata[LEN_W-1:0];
            CSR_PATTERN_BYTES_0: words_in[0] = csr_wdata;
            CSR_PATTERN_BYTES_1: words_in[1] = csr_wdata;
            CSR_PATTERN_BYTES_2: words_in[2] = csr_wdata;
            CSR_PATTERN_BYTES_3: words_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         words_ff <= '0;
      end else begin
         len_ff   <= len_in;
         words_ff <= words_in;
      end
   end

   assign eff_len   = (len_ff > LEN_W'(PAT_CAP)) ? LEN_W'(PAT_CAP) : len_ff;
   assign all_bytes = words_ff;

   always_comb begin
      cfg.eff_len = eff_len;
      for (int j = 0; j < POS_W; j++) begin
         cfg.keep[j] = (LEN_W'(j) <= eff_len);
      end
      for (int i = 0; i < PAT_CAP; i++) begin
         cfg.star[i]      = (all_bytes[i] == STAR_BYTE) && (LEN_W'(i) < eff_len);
         cfg.qmark[i]     = (all_bytes[i] == QUESTION_BYTE);
         cfg.fold_byte[i] = fold_case(all_bytes[i]);
      end
   end

endmodule

### design/wgm_step.sv
// ----------------------------------------------------------------------------
// wgm_step
// Next live-position set and verdict for one item.
// ----------------------------------------------------------------------------
module wgm_step
   import wgm_pkg::*;
(
   input  cfg_type      cfg,
   input  pos_vec_type  live,
   input  logic         at_start,
   input  logic [7:0]   text_byte,
   input  logic         has_byte,
   output pos_vec_type  next_live,
   output logic         matched
);

   pos_vec_type set0;
   pos_vec_type adv;
   pos_vec_type set1;
   logic [7:0]  text_fold;

   assign text_fold = fold_case(text_byte);
   assign set0      = close_stars(at_start ? POS_W'(1) : live, cfg);

   always_comb begin
      adv = '0;
      for (int i = 0; i < PAT_CAP; i++) begin
         if (set0[i] && (LEN_W'(i) < cfg.eff_len)) begin
            if (cfg.star[i]) begin
               adv[i] = 1'b1;
            end else if (cfg.qmark[i] || (cfg.fold_byte[i] == text_fold)) begin
               adv[i+1] = 1'b1;
            end
         end
      end
   end

   assign set1      = has_byte ? close_stars(adv, cfg) : set0;
   assign next_live = set1;
   assign matched   = set1[cfg.eff_len[POS_IDX_W-1:0]];

endmodule

### design/wildcard_glob_matcher_top.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_top
// Glob matcher ('*' and '?', case-folded letters) over a byte stream.
// ----------------------------------------------------------------------------
// a last item passes the input register, then the result register, before rsp_valid
// throughput: one item per cycle through the live-set update loop, unless a last item
// waits for the result slot to free; an input register feeds the step logic and a result
// register holds the verdict; reset (synchronous, active high) clears the pattern, the
// live set and both valid flags, and arms the matcher for the start of a new string
module wildcard_glob_matcher_top
   import wgm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_has_byte,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_matched,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg;
   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;
   logic        in_has_ff;
   logic        in_last_ff;
   pos_vec_type live_ff;
   logic        start_ff;
   logic        rsp_vld_ff;
   logic        rsp_match_ff;
   pos_vec_type next_live;
   logic        step_match;
   logic        out_free;
   logic        advance;

   wgm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wgm_step u_step (
      .cfg       (cfg),
      .live      (live_ff),
      .at_start  (start_ff),
      .text_byte (in_byte_ff),
      .has_byte  (in_has_ff),
      .next_live (next_live),
      .matched   (step_match)
   );

   // only a last item needs the result slot
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign advance   = in_vld_ff && (!in_last_ff || out_free);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_has_ff  <= req_has_byte;
         in_last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         start_ff <= 1'b1;
      end else if (advance) begin
         if (in_last_ff) begin
            live_ff  <= '0;
            start_ff <= 1'b1;
         end else begin
            live_ff  <= next_live;
            start_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_match_ff <= step_match;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_matched = rsp_match_ff;

endmodule

### design/wgm_checker.sv
// ----------------------------------------------------------------------------
// wgm_checker
// Port-level checks on the glob matcher, bound to the top level.
// ----------------------------------------------------------------------------
module wgm_checker
   import wgm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_matched
);

   // a held result keeps its verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched))
      else $error("result changed while stalled");

   a_rsp_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // a fresh result follows a last item taken at the request port, across the input register and the result register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("result without a last item");

   // with the result slot empty the input side never stalls
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with result slot empty");

endmodule

bind wildcard_glob_matcher_top wgm_checker u_wgm_checker (.*);
